// ----- hw/rtl/r2ifft_pkg.sv -----
// Package: sizes, twiddle table and state codes for the radix-2 DIF IFFT core.
package r2ifft_pkg;

  localparam int POINTS      = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(POINTS);
  localparam int STAGE_BITS  = $clog2(ADDR_BITS + 1);
  localparam int WORD_BITS   = 2 * SAMPLE_BITS;
  localparam int TW_FRAC     = 15;
  localparam int TW_BITS     = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [STAGE_BITS-1:0]         stage_t;
  typedef logic signed [TW_BITS-1:0]     tw_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_A,
    ST_RD_B,
    ST_CALC,
    ST_WR_B,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // Cosine of 2*pi*k/64 in Q1.15.
  function automatic tw_t tw_cos(input addr_t k);
    tw_t q [0:16];
    tw_t v;
    logic [1:0] quad;
    logic [3:0] r;
    q = '{16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
          16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
          16'sd12540, 16'sd9512, 16'sd6393, 16'sd3212, 16'sd0};
    quad = k[5:4];
    r    = k[3:0];
    unique case (quad)
      2'd0: v = q[r];
      2'd1: v = -q[16 - r];
      2'd2: v = -q[r];
      default: v = q[16 - r];
    endcase
    return v;
  endfunction

  // Sine of 2*pi*k/64 in Q1.15.
  function automatic tw_t tw_sin(input addr_t k);
    return tw_cos(addr_t'(k - addr_t'(POINTS / 4)));
  endfunction

  function automatic addr_t bit_rev(input addr_t k);
    addr_t r;
    for (int b = 0; b < ADDR_BITS; b++) r[ADDR_BITS-1-b] = k[b];
    return r;
  endfunction

  function automatic sample_t sat_s(input logic signed [SAMPLE_BITS+17:0] v);
    sample_t r;
    if (v > (SAMPLE_BITS+18)'(signed'(2**(SAMPLE_BITS-1) - 1)))
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else if (v < -(SAMPLE_BITS+18)'(signed'(2**(SAMPLE_BITS-1))))
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else
      r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/r2ifft_if.sv -----
// Interfaces: valid/ready channels for input samples and output samples.
interface r2ifft_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [r2ifft_pkg::SAMPLE_BITS-1:0] in_real;
  logic signed [r2ifft_pkg::SAMPLE_BITS-1:0] in_imag;
  modport source (output valid, in_real, in_imag, input ready);
  modport sink (input valid, in_real, in_imag, output ready);
endinterface

interface r2ifft_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [r2ifft_pkg::SAMPLE_BITS-1:0] out_real;
  logic signed [r2ifft_pkg::SAMPLE_BITS-1:0] out_imag;
  logic [r2ifft_pkg::ADDR_BITS-1:0]          out_index;
  logic                        out_last;
  modport source (output valid, out_real, out_imag, out_index, out_last, input ready);
  modport sink (input valid, out_real, out_imag, out_index, out_last, output ready);
endinterface

// ----- hw/rtl/r2ifft_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module r2ifft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/r2ifft_bfly.sv -----
// Butterfly datapath: registered sum, complex product, round, saturate.
module r2ifft_bfly (
  input  logic                   clk,
  input  r2ifft_pkg::sample_t    ar,
  input  r2ifft_pkg::sample_t    ai,
  input  r2ifft_pkg::sample_t    br,
  input  r2ifft_pkg::sample_t    bi,
  input  r2ifft_pkg::addr_t      tw_idx,
  input  logic                   calc,
  output r2ifft_pkg::sample_t    top_r,
  output r2ifft_pkg::sample_t    top_i,
  output r2ifft_pkg::sample_t    bot_r,
  output r2ifft_pkg::sample_t    bot_i
);
  localparam int SB = r2ifft_pkg::SAMPLE_BITS;
  localparam int WB = SB + 18;
  localparam int PB = SB + 1 + r2ifft_pkg::TW_BITS;

  logic signed [SB:0]   dr, di;
  r2ifft_pkg::tw_t      wr, wi;
  logic signed [PB-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [WB-1:0] sum_r, sum_i, rot_r, rot_i;
  logic signed [WB-1:0] dif_r, dif_i;
  logic                 unity;

  // Store sums, differences, twiddle factors and the unity flag at the compute step.
  always_ff @(posedge clk) begin
    if (calc) begin
      dr    <= (SB+1)'(ar) - (SB+1)'(br);
      di    <= (SB+1)'(ai) - (SB+1)'(bi);
      sum_r <= WB'(ar) + WB'(br) + WB'(1);
      sum_i <= WB'(ai) + WB'(bi) + WB'(1);
      unity <= (tw_idx == '0);
      wr    <= r2ifft_pkg::tw_cos(tw_idx);
      wi    <= r2ifft_pkg::tw_sin(tw_idx);
    end
  end

  assign p_rr  = dr * wr;
  assign p_ii  = di * wi;
  assign p_ri  = dr * wi;
  assign p_ir  = di * wr;
  assign rot_r = WB'(p_rr) - WB'(p_ii) + WB'(1 <<< r2ifft_pkg::TW_FRAC);
  assign rot_i = WB'(p_ri) + WB'(p_ir) + WB'(1 <<< r2ifft_pkg::TW_FRAC);
  assign dif_r = WB'(dr) + WB'(1);
  assign dif_i = WB'(di) + WB'(1);

  assign top_r = r2ifft_pkg::sat_s(sum_r >>> 1);
  assign top_i = r2ifft_pkg::sat_s(sum_i >>> 1);
  assign bot_r = unity ? r2ifft_pkg::sat_s(dif_r >>> 1)
                       : r2ifft_pkg::sat_s(rot_r >>> (r2ifft_pkg::TW_FRAC + 1));
  assign bot_i = unity ? r2ifft_pkg::sat_s(dif_i >>> 1)
                       : r2ifft_pkg::sat_s(rot_i >>> (r2ifft_pkg::TW_FRAC + 1));
endmodule

// ----- hw/rtl/radix2_dif_ifft_core.sv -----
// Top level: 64-point radix-2 DIF inverse FFT around one sample memory.
//
//  channel | dir | fields                               | accepted when
//  s_in    | in  | in_real, in_imag                     | valid && ready
//  m_out   | out | out_real, out_imag, out_index, last  | valid && ready
//
// Load accepts one item per cycle while s_in.valid is high, 64 items in all. Each butterfly
// steps through the states RD_A, RD_B, CALC and WR_B around the single read / single
// write port of the sample memory: read a, read b, compute, write bottom; top is written
// in the following cycle, while the next butterfly reads a (or the first emit read runs).
// 6 stages x 32 = 192 butterflies. Emit reads the memory at bit-reversed addresses, in an
// EMIT_RD and an EMIT_OUT state per item; a new symbol loads only after the last item is taken.
// Reset (rst, synchronous) returns to load with zero count; memory is not cleared.
// A stalled output holds the item; the sequencer waits on m_out.ready.
module radix2_dif_ifft_core (
  input logic clk,
  input logic rst,
  r2ifft_in_if.sink    s_in,
  r2ifft_out_if.source m_out
);
  localparam int AB = r2ifft_pkg::ADDR_BITS;
  localparam int SB = r2ifft_pkg::SAMPLE_BITS;

  r2ifft_pkg::state_t state, state_next;
  r2ifft_pkg::addr_t  cnt, cnt_next;      // load count, butterfly or emit index
  r2ifft_pkg::stage_t stage, stage_next;  // stage being run, from 0
  logic               cnt_wrap;

  logic                               we;
  r2ifft_pkg::addr_t                  waddr, raddr;
  logic [r2ifft_pkg::WORD_BITS-1:0]   wdata, rdata;
  r2ifft_pkg::sample_t                ar, ai;
  r2ifft_pkg::sample_t                top_r, top_i, bot_r, bot_i;

  // Butterfly addresses for index cnt in this stage.
  r2ifft_pkg::addr_t half, lowmask, ia, ib, tw_idx;
  assign half    = AB'(r2ifft_pkg::POINTS / 2) >> stage;
  assign lowmask = half - AB'(1);
  assign ia      = ((cnt & ~lowmask) << 1) | (cnt & lowmask);
  assign ib      = ia | half;
  assign tw_idx  = (cnt & lowmask) << stage;
  assign cnt_wrap = (cnt == AB'(r2ifft_pkg::POINTS / 2 - 1));

  // Hold operand a after its read.
  always_ff @(posedge clk) begin
    if (state == r2ifft_pkg::ST_RD_B) begin
      ar <= rdata[2*SB-1:SB];
      ai <= rdata[SB-1:0];
    end
  end

  r2ifft_bfly u_bfly (
    .clk, .ar, .ai,
    .br(rdata[2*SB-1:SB]), .bi(rdata[SB-1:0]),
    .tw_idx, .calc(state == r2ifft_pkg::ST_CALC),
    .top_r, .top_i, .bot_r, .bot_i
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2ifft_pkg::ST_LOAD;
      cnt   <= '0;
      stage <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      stage <= stage_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    stage_next = stage;
    unique case (state)
      r2ifft_pkg::ST_LOAD: begin
        if (s_in.valid) begin
          cnt_next = cnt + AB'(1);
          if (cnt == AB'(r2ifft_pkg::POINTS - 1)) state_next = r2ifft_pkg::ST_RD_A;
        end
      end
      r2ifft_pkg::ST_RD_A: state_next = r2ifft_pkg::ST_RD_B;
      r2ifft_pkg::ST_RD_B: state_next = r2ifft_pkg::ST_CALC;
      r2ifft_pkg::ST_CALC: state_next = r2ifft_pkg::ST_WR_B;
      r2ifft_pkg::ST_WR_B: begin
        state_next = r2ifft_pkg::ST_RD_A;
        cnt_next   = cnt_wrap ? '0 : cnt + AB'(1);
        if (cnt_wrap) begin
          if (stage == r2ifft_pkg::stage_t'(AB - 1)) begin
            stage_next = '0;
            state_next = r2ifft_pkg::ST_EMIT_RD;
          end else begin
            stage_next = stage + r2ifft_pkg::stage_t'(1);
          end
        end
      end
      r2ifft_pkg::ST_EMIT_RD: state_next = r2ifft_pkg::ST_EMIT_OUT;
      r2ifft_pkg::ST_EMIT_OUT: begin
        if (m_out.ready) begin
          cnt_next   = cnt + AB'(1);
          state_next = (cnt == AB'(r2ifft_pkg::POINTS - 1)) ? r2ifft_pkg::ST_LOAD
                                                            : r2ifft_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = r2ifft_pkg::ST_LOAD;
    endcase
  end

  // Memory port and channel outputs.
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {s_in.in_real, s_in.in_imag};
    raddr = ia;
    s_in.ready  = 1'b0;
    m_out.valid = 1'b0;
    unique case (state)
      r2ifft_pkg::ST_LOAD: begin
        s_in.ready = 1'b1;
        we         = s_in.valid;
      end
      r2ifft_pkg::ST_RD_A: raddr = ia;
      r2ifft_pkg::ST_RD_B: raddr = ib;
      r2ifft_pkg::ST_CALC: raddr = ib;
      r2ifft_pkg::ST_WR_B: begin
        we    = 1'b1;
        waddr = ib;
        wdata = {bot_r, bot_i};
      end
      r2ifft_pkg::ST_EMIT_RD: raddr = r2ifft_pkg::bit_rev(cnt);
      r2ifft_pkg::ST_EMIT_OUT: begin
        raddr       = r2ifft_pkg::bit_rev(cnt);
        m_out.valid = 1'b1;
      end
      default: ;
    endcase
  end

  // Hold top and write it in the cycle after WR_B, the RD_A of the next
  // butterfly (or the first emit read), when the write port is free.
  r2ifft_pkg::sample_t top_r_q, top_i_q;
  r2ifft_pkg::addr_t   ia_q;
  logic                top_pend;
  always_ff @(posedge clk) begin
    if (state == r2ifft_pkg::ST_WR_B) begin
      top_r_q <= top_r;
      top_i_q <= top_i;
      ia_q    <= ia;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) top_pend <= 1'b0;
    else     top_pend <= (state == r2ifft_pkg::ST_WR_B);
  end

  // Merge the delayed top write onto the single write port.
  logic                             we2, we_m;
  logic [r2ifft_pkg::WORD_BITS-1:0] wdata_m;
  r2ifft_pkg::addr_t                waddr_m;
  assign we2     = top_pend;
  assign we_m    = we | we2;
  assign waddr_m = we2 ? ia_q : waddr;
  assign wdata_m = we2 ? {top_r_q, top_i_q} : wdata;

  r2ifft_ram #(.WIDTH(r2ifft_pkg::WORD_BITS), .DEPTH(r2ifft_pkg::POINTS)) u_store (
    .clk, .we(we_m), .waddr(waddr_m), .wdata(wdata_m), .raddr, .rdata
  );

  assign m_out.out_real  = rdata[2*SB-1:SB];
  assign m_out.out_imag  = rdata[SB-1:0];
  assign m_out.out_index = cnt;
  assign m_out.out_last  = (cnt == AB'(r2ifft_pkg::POINTS - 1));

  a_top_write: assert property (@(posedge clk) disable iff (rst)
    top_pend |-> (state == r2ifft_pkg::ST_RD_A || state == r2ifft_pkg::ST_EMIT_RD))
    else $error("top write outside its slot");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != r2ifft_pkg::ST_LOAD) |-> !s_in.ready)
    else $error("input taken while busy");
  a_emit_after: assert property (@(posedge clk) disable iff (rst)
    (state == r2ifft_pkg::ST_EMIT_RD && $past(state) == r2ifft_pkg::ST_WR_B)
      |-> cnt == '0)
    else $error("emit does not start at index zero");
endmodule

// ----- dv/radix2_dif_ifft_core_tb.sv -----
// Testbench for the 64-point radix-2 DIF inverse FFT core: random symbols against a predictor.
module radix2_dif_ifft_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef r2ifft_pkg::sample_t sample_t;
  typedef r2ifft_pkg::addr_t   addr_t;
  localparam int POINTS    = r2ifft_pkg::POINTS;
  localparam int ADDR_BITS = r2ifft_pkg::ADDR_BITS;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_SYMBOLS = 8;

  typedef struct {
    sample_t re;
    sample_t im;
    int      gap;    // cycles to idle before offering this item
    bit      drain;  // hold off until every pending output has come back
  } sample_item_t;

  typedef struct {
    sample_t re;
    sample_t im;
    addr_t   idx;
    logic    last;
  } freq_bin_t;

  logic clk;
  logic rst;

  r2ifft_in_if  in_ch ();
  r2ifft_out_if out_ch ();

  radix2_dif_ifft_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .s_in  (in_ch.sink),
    .m_out (out_ch.source)
  );

  sample_item_t tx_queue [$];
  freq_bin_t    pending_bins [$];

  // Predictor state: the symbol being collected and the twiddle table.
  longint sym_re [POINTS];
  longint sym_im [POINTS];
  longint rot_cos [POINTS];
  longint rot_sin [POINTS];
  int     fill_level;

  int  error_count;
  int  results_seen;
  int  samples_taken;
  int  cycle_count;
  int  hold_left;
  bit  long_hold_done;
  bit  in_fire;
  bit  out_fire;

  // Q2.30 fixed-point multiply, truncating.
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Taylor sine/cosine in Q2.30 for 0 <= x <= pi/4; build_twiddles rounds them to Q1.15.
  function automatic void taylor_sin_cos(longint unsigned x, output longint s,
                                         output longint c);
    longint unsigned x2, ts, tc;
    x2 = q30_mul(x, x);
    ts = x;
    tc = 64'd1073741824;
    s  = longint'(x);
    c  = 64'sd1073741824;
    for (int n = 1; n <= 5; n++) begin
      ts = q30_mul(ts, x2) / ((2 * n) * (2 * n + 1));
      tc = q30_mul(tc, x2) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
  endfunction

  function automatic longint to_q15(longint v);
    longint r;
    if (v < 0) v = 0;
    r = (v + (64'sd1 << 14)) >>> 15;
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic void build_twiddles();
    int unsigned quad, rem;
    bit swap;
    longint s, c, t;
    for (int k = 0; k < POINTS; k++) begin
      quad = (4 * k) / POINTS;
      rem  = (4 * k) % POINTS;
      swap = (2 * rem) > POINTS;
      if (swap) rem = POINTS - rem;
      taylor_sin_cos((64'd3373259426 * rem) / (2 * POINTS), s, c);
      if (swap) begin
        t = s;
        s = c;
        c = t;
      end
      c = to_q15(c);
      s = to_q15(s);
      case (quad % 4)
        0: begin rot_cos[k] = c;  rot_sin[k] = s;  end
        1: begin rot_cos[k] = -s; rot_sin[k] = c;  end
        2: begin rot_cos[k] = -c; rot_sin[k] = -s; end
        default: begin rot_cos[k] = s; rot_sin[k] = -c; end
      endcase
    end
  endfunction

  // Round half up then shift: floor((v + 2^(n-1)) / 2^n).
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 << (n - 1))) >>> n;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic addr_t reverse_addr(addr_t k);
    addr_t r;
    for (int b = 0; b < ADDR_BITS; b++) r[ADDR_BITS - 1 - b] = k[b];
    return r;
  endfunction

  // Run all butterfly stages in place, then queue the 64 bins in natural order.
  task automatic transform_symbol();
    int half, step, ia, ib, k;
    longint ar, ai, br, bi, dr, di;
    freq_bin_t bin;
    for (int s = 1; s <= ADDR_BITS; s++) begin
      half = POINTS >> s;
      step = 1 << (s - 1);
      for (int m = 0; m < POINTS; m += 2 * half) begin
        for (int i = 0; i < half; i++) begin
          ia = m + i;
          ib = m + i + half;
          ar = sym_re[ia];
          ai = sym_im[ia];
          br = sym_re[ib];
          bi = sym_im[ib];
          dr = ar - br;
          di = ai - bi;
          k  = (i * step) % POINTS;
          sym_re[ia] = clip16(round_shift(ar + br, 1));
          sym_im[ia] = clip16(round_shift(ai + bi, 1));
          if (k == 0) begin
            sym_re[ib] = clip16(round_shift(dr, 1));
            sym_im[ib] = clip16(round_shift(di, 1));
          end else begin
            sym_re[ib] = clip16(round_shift(dr * rot_cos[k] - di * rot_sin[k], 16));
            sym_im[ib] = clip16(round_shift(dr * rot_sin[k] + di * rot_cos[k], 16));
          end
        end
      end
    end
    for (int n = 0; n < POINTS; n++) begin
      bin.re   = sample_t'(sym_re[reverse_addr(addr_t'(n))]);
      bin.im   = sample_t'(sym_im[reverse_addr(addr_t'(n))]);
      bin.idx  = addr_t'(n);
      bin.last = (n == POINTS - 1);
      pending_bins.push_back(bin);
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at bin %0d: %s got %0d expected %0d", results_seen, field, got, want);
    error_count++;
  endtask

  // Draw one sample value of the given flavor: full range, small, or rail.
  function automatic sample_t pick_value(int flavor);
    case (flavor)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 512) - 256);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit guards against a hung core.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Note input acceptance and feed the predictor with each accepted item.
  always @(posedge clk) begin
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      sym_re[fill_level] = longint'(in_ch.in_real);
      sym_im[fill_level] = longint'(in_ch.in_imag);
      samples_taken++;
      if (fill_level == POINTS - 1) begin
        fill_level = 0;
        transform_symbol();
      end else begin
        fill_level++;
      end
    end
  end

  // Driver: present the next queued item after its gap; drop valid once taken.
  always @(negedge clk) begin
    logic v;
    v = in_ch.valid;
    if (rst) begin
      v = 1'b0;
    end else begin
      if (in_fire) v = 1'b0;
      if (!v && tx_queue.size() > 0) begin
        if (tx_queue[0].drain && pending_bins.size() > 0) begin
          // hold until the core has handed back everything
        end else if (tx_queue[0].gap > 0) begin
          tx_queue[0].gap--;
        end else begin
          in_ch.in_real <= tx_queue[0].re;
          in_ch.in_imag <= tx_queue[0].im;
          tx_queue.pop_front();
          v = 1'b1;
        end
      end
    end
    in_ch.valid <= v;
  end

  // Monitor: compare each accepted bin with the oldest prediction.
  always @(posedge clk) begin
    freq_bin_t want;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_bins.size() == 0) begin
        report_mismatch("unexpected bin index", out_ch.out_index, -1);
      end else begin
        want = pending_bins.pop_front();
        if (out_ch.out_real !== want.re) report_mismatch("out_real", out_ch.out_real, want.re);
        if (out_ch.out_imag !== want.im) report_mismatch("out_imag", out_ch.out_imag, want.im);
        if (out_ch.out_index !== want.idx)
          report_mismatch("out_index", out_ch.out_index, want.idx);
        if (out_ch.out_last !== want.last)
          report_mismatch("out_last", out_ch.out_last, want.last);
      end
      results_seen++;
    end
  end

  // Receiver: after each bin draw a stall, except in every third symbol; one long stall fills the core up.
  always @(negedge clk) begin
    int h;
    h = hold_left;
    if (rst) begin
      h = $urandom_range(0, 19);
    end else if (out_fire) begin
      if (!long_hold_done && results_seen >= 100) begin
        h = 3000;
        long_hold_done = 1'b1;
      end else if ((results_seen / POINTS) % 3 == 1) begin
        h = 0;  // stretch with the receiver always ready
      end else begin
        h = $urandom_range(0, 19);
      end
    end
    if (h > 0) begin
      out_ch.ready <= 1'b0;
      h--;
    end else begin
      out_ch.ready <= 1'b1;
    end
    hold_left = h;
  end

  // Stimulus, end of test and verdict.
  initial begin
    sample_item_t it;
    sample_t rails [8];
    int flavor;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_real = '0;
    in_ch.in_imag = '0;
    out_ch.ready  = 1'b0;
    error_count   = 0;
    results_seen  = 0;
    samples_taken = 0;
    cycle_count   = 0;
    fill_level    = 0;
    hold_left     = 0;
    in_fire       = 1'b0;
    out_fire      = 1'b0;
    long_hold_done = 1'b0;
    build_twiddles();

    // Directed head of the first symbol: rails, zero, +/-1 and mixed signs.
    rails = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
              16'sh7fff, 16'sh8000, 16'sh4000};
    for (int n = 0; n < 24; n++) begin
      it.re    = rails[n % 8];
      it.im    = rails[(n / 3 + n) % 8];
      it.gap   = 0;
      it.drain = 1'b0;
      tx_queue.push_back(it);
    end

    // Rest of the items: symbol 1 is rails-only and pushes the butterflies into saturation.
    for (int n = 24; n < NUM_SYMBOLS * POINTS; n++) begin
      flavor   = (n / POINTS == 1) ? 2 : $urandom_range(0, 2);
      it.re    = pick_value(flavor);
      it.im    = pick_value(flavor);
      it.gap   = ((n / POINTS) % 4 == 2) ? 0 : $urandom_range(0, 19);
      it.drain = (n == 5 * POINTS);
      tx_queue.push_back(it);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (tx_queue.size() == 0 && !in_ch.valid);
    wait (pending_bins.size() == 0);
    repeat (1200) @(posedge clk);

    if (pending_bins.size() != 0) begin
      $display("%0d predicted bins never arrived", pending_bins.size());
      error_count++;
    end
    $display("covered %0d samples in %0d symbols, %0d bins checked, %0d errors",
             samples_taken, samples_taken / POINTS, results_seen, error_count);
    $display("rail, small and full-range data with random stalls on both channels");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/r2ifft_pkg.sv
hw/rtl/r2ifft_if.sv
hw/rtl/r2ifft_ram.sv
hw/rtl/r2ifft_bfly.sv
hw/rtl/radix2_dif_ifft_core.sv
dv/radix2_dif_ifft_core_tb.sv
